// ===== hdl/iws_pkg.sv =====
// ----------------------------------------------------------------------------
// Ignition window sequencer package
// Shared widths, register indexes, phase codes and the structs that carry
// configuration, one input tick and one result between the modules.
// ----------------------------------------------------------------------------
package iws_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned CNT16_W    = 16;
  localparam int unsigned CNT24_W    = 24;
  localparam int unsigned PHASE_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_THRESHOLD = 4'd0,
    REG_SAMPLE_PERIOD    = 4'd1,
    REG_DEBOUNCE         = 4'd2,
    REG_WAIT_WINDOW      = 4'd3,
    REG_WINDOW_LENGTH    = 4'd4,
    REG_SEP_DELAY        = 4'd5,
    REG_SLEEP_AFTER      = 4'd6,
    REG_LOG_PERIOD       = 4'd7
  } reg_idx_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_INIT    = 3'd0,
    PH_GROUND  = 3'd1,
    PH_FLYING  = 3'd2,
    PH_WINDOW  = 3'd3,
    PH_INHIBIT = 3'd4,
    PH_GND_CFG = 3'd5
  } phase_e;

  localparam logic [SAMPLE_W-1:0] RST_SENSOR_THRESHOLD = 12'd2048;
  localparam logic [CNT16_W-1:0]  RST_SAMPLE_PERIOD    = 16'd10;
  localparam logic [CNT16_W-1:0]  RST_DEBOUNCE         = 16'd100;
  localparam logic [CNT24_W-1:0]  RST_WAIT_WINDOW      = 24'd5000;
  localparam logic [CNT24_W-1:0]  RST_WINDOW_LENGTH    = 24'd2000;
  localparam logic [CNT24_W-1:0]  RST_SEP_DELAY        = 24'd500;
  localparam logic [CNT24_W-1:0]  RST_SLEEP_AFTER      = 24'd3600000;
  localparam logic [CNT16_W-1:0]  RST_LOG_PERIOD       = 16'd1000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sensor_threshold;
    logic [CNT16_W-1:0]  sample_period_ms;
    logic [CNT16_W-1:0]  debounce_ms;
    logic [CNT24_W-1:0]  wait_before_window_ms;
    logic [CNT24_W-1:0]  window_length_ms;
    logic [CNT24_W-1:0]  separation_delay_ms;
    logic [CNT24_W-1:0]  sleep_after_ms;
    logic [CNT16_W-1:0]  log_period_ms;
  } cfg_t;

  typedef struct packed {
    logic                umbilical_out;
    logic                switch_one;
    logic                switch_two;
    logic                nose_switch;
    logic                trajectory_ok;
    logic [SAMPLE_W-1:0] sensor_sample;
  } item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               ignite_n;
    logic               separated_flag;
    logic               status_indicator;
    logic               log_request;
    logic               sleep_request;
  } res_t;

  // Counter increment that sticks at the all-ones value.
  function automatic logic [CNT24_W-1:0] sat24_inc(input logic [CNT24_W-1:0] v);
    logic [CNT24_W-1:0] r;
    r = (&v) ? v : v + 24'd1;
    return r;
  endfunction

endpackage

// ===== hdl/iws_in_if.sv =====
// ----------------------------------------------------------------------------
// Input tick channel
// Valid/ready channel carrying the pin levels and ADC sample of one tick.
// ----------------------------------------------------------------------------
interface iws_in_if;
  import iws_pkg::*;

  logic                valid;
  logic                ready;
  logic                umbilical_out;
  logic                switch_one;
  logic                switch_two;
  logic                nose_switch;
  logic                trajectory_ok;
  logic [SAMPLE_W-1:0] sensor_sample;

  modport source (
    output valid, umbilical_out, switch_one, switch_two, nose_switch,
           trajectory_ok, sensor_sample,
    input  ready
  );
  modport sink (
    input  valid, umbilical_out, switch_one, switch_two, nose_switch,
           trajectory_ok, sensor_sample,
    output ready
  );
endinterface

// ===== hdl/iws_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the sequencer outputs of one tick.
// ----------------------------------------------------------------------------
interface iws_out_if;
  import iws_pkg::*;

  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] phase;
  logic               ignite_n;
  logic               separated_flag;
  logic               status_indicator;
  logic               log_request;
  logic               sleep_request;

  modport source (
    output valid, phase, ignite_n, separated_flag, status_indicator,
           log_request, sleep_request,
    input  ready
  );
  modport sink (
    input  valid, phase, ignite_n, separated_flag, status_indicator,
           log_request, sleep_request,
    output ready
  );
endinterface

// ===== hdl/iws_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface iws_cfg_if;
  import iws_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/iws_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the eight sequencer settings; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module iws_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  iws_cfg_if.sink       cfg_i,
  output iws_pkg::cfg_t cfg_o
);
  import iws_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_threshold      <= RST_SENSOR_THRESHOLD;
      cfg_q.sample_period_ms      <= RST_SAMPLE_PERIOD;
      cfg_q.debounce_ms           <= RST_DEBOUNCE;
      cfg_q.wait_before_window_ms <= RST_WAIT_WINDOW;
      cfg_q.window_length_ms      <= RST_WINDOW_LENGTH;
      cfg_q.separation_delay_ms   <= RST_SEP_DELAY;
      cfg_q.sleep_after_ms        <= RST_SLEEP_AFTER;
      cfg_q.log_period_ms         <= RST_LOG_PERIOD;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (reg_idx_e'(cfg_i.index))
        REG_SENSOR_THRESHOLD: cfg_q.sensor_threshold      <= cfg_i.data[SAMPLE_W-1:0];
        REG_SAMPLE_PERIOD:    cfg_q.sample_period_ms      <= cfg_i.data[CNT16_W-1:0];
        REG_DEBOUNCE:         cfg_q.debounce_ms           <= cfg_i.data[CNT16_W-1:0];
        REG_WAIT_WINDOW:      cfg_q.wait_before_window_ms <= cfg_i.data[CNT24_W-1:0];
        REG_WINDOW_LENGTH:    cfg_q.window_length_ms      <= cfg_i.data[CNT24_W-1:0];
        REG_SEP_DELAY:        cfg_q.separation_delay_ms   <= cfg_i.data[CNT24_W-1:0];
        REG_SLEEP_AFTER:      cfg_q.sleep_after_ms        <= cfg_i.data[CNT24_W-1:0];
        REG_LOG_PERIOD:       cfg_q.log_period_ms         <= cfg_i.data[CNT16_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/iws_core.sv =====
// ----------------------------------------------------------------------------
// Sequencer core
// Phase machine, tick timers and separation vote; computes one result per
// step from the registered input tick and updates the state on that step.
// ----------------------------------------------------------------------------
module iws_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  iws_pkg::item_t item_i,
  input  iws_pkg::cfg_t  cfg_i,
  output iws_pkg::res_t  res_o
);
  import iws_pkg::*;

  phase_e              phase_q, phase_d;
  logic [CNT24_W-1:0]  since_takeoff_q, since_takeoff_d;
  logic [CNT16_W-1:0]  debounce_q, debounce_d;
  logic [CNT24_W-1:0]  since_sep_q, since_sep_d;
  logic [CNT16_W-1:0]  sample_timer_q, sample_timer_d;
  logic [CNT16_W-1:0]  log_timer_q, log_timer_d;
  logic                separated_q, separated_d;
  logic                contact_q, contact_d;
  logic                ignite_n_q, ignite_n_d;

  logic [CNT16_W:0]    log_next;
  logic [CNT24_W:0]    window_end;
  logic                log_req, sleep_req, ind;
  logic                armed;

  always_comb begin
    log_next   = {1'b0, log_timer_q} + 17'd1;
    window_end = {1'b0, cfg_i.wait_before_window_ms} + {1'b0, cfg_i.window_length_ms};
    log_req    = 1'b0;
    sleep_req  = 1'b0;
    ind        = 1'b1;

    if (log_next >= {1'b0, cfg_i.log_period_ms}) begin
      log_req     = 1'b1;
      log_timer_d = '0;
    end else begin
      log_timer_d = log_next[CNT16_W-1:0];
    end

    since_sep_d = separated_q ? sat24_inc(since_sep_q) : '0;

    contact_d   = contact_q;
    separated_d = separated_q;
    if (sample_timer_q >= cfg_i.sample_period_ms) begin
      sample_timer_d = '0;
      contact_d      = item_i.sensor_sample > cfg_i.sensor_threshold;
      // Separated when at least two of the three sensors say so.
      separated_d    = (!item_i.switch_one && !item_i.switch_two) ||
                       (!item_i.switch_one && !contact_d) ||
                       (!item_i.switch_two && !contact_d);
    end else begin
      sample_timer_d = sample_timer_q + 16'd1;
    end

    since_takeoff_d = since_takeoff_q;
    if (!(phase_q inside {PH_INIT, PH_GROUND, PH_GND_CFG})) begin
      since_takeoff_d = sat24_inc(since_takeoff_q);
    end

    phase_d    = phase_q;
    debounce_d = debounce_q;
    ignite_n_d = ignite_n_q;
    armed      = separated_d && !item_i.nose_switch && item_i.trajectory_ok;

    case (phase_q)
      PH_INIT: begin
        phase_d         = item_i.umbilical_out ? PH_GND_CFG : PH_GROUND;
        since_takeoff_d = '0;
        log_req         = 1'b1;
      end
      PH_GROUND: begin
        ind = separated_d;
        if (item_i.umbilical_out) begin
          if (debounce_q >= cfg_i.debounce_ms) begin
            since_takeoff_d = {{(CNT24_W-CNT16_W){1'b0}}, debounce_q};
            debounce_d      = '0;
            phase_d         = PH_FLYING;
            log_req         = 1'b1;
          end else begin
            debounce_d = debounce_q + 16'd1;
          end
        end else begin
          debounce_d = '0;
        end
      end
      PH_FLYING: begin
        ind = !armed;
        if (since_takeoff_d > cfg_i.wait_before_window_ms) begin
          phase_d = PH_WINDOW;
          log_req = 1'b1;
        end
      end
      PH_WINDOW: begin
        ignite_n_d = !((since_sep_d > cfg_i.separation_delay_ms) &&
                       !item_i.nose_switch && item_i.trajectory_ok);
        ind        = !armed;
        if ({1'b0, since_takeoff_d} > window_end) begin
          ignite_n_d = 1'b1;
          ind        = 1'b1;
          phase_d    = PH_INHIBIT;
          log_req    = 1'b1;
        end
      end
      PH_GND_CFG: begin
        ind = separated_d;
      end
      default: begin
        ignite_n_d = 1'b1;
        if (since_takeoff_d > cfg_i.sleep_after_ms) begin
          sleep_req = 1'b1;
          log_req   = 1'b1;
        end
      end
    endcase

    res_o.phase            = phase_d;
    res_o.ignite_n         = ignite_n_d;
    res_o.separated_flag   = separated_d;
    res_o.status_indicator = ind;
    res_o.log_request      = log_req;
    res_o.sleep_request    = sleep_req;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_INIT;
      since_takeoff_q <= '0;
      debounce_q      <= '0;
      since_sep_q     <= '0;
      sample_timer_q  <= '0;
      log_timer_q     <= '0;
      separated_q     <= 1'b1;
      contact_q       <= 1'b0;
      ignite_n_q      <= 1'b1;
    end else if (step_i) begin
      phase_q         <= phase_d;
      since_takeoff_q <= since_takeoff_d;
      debounce_q      <= debounce_d;
      since_sep_q     <= since_sep_d;
      sample_timer_q  <= sample_timer_d;
      log_timer_q     <= log_timer_d;
      separated_q     <= separated_d;
      contact_q       <= contact_d;
      ignite_n_q      <= ignite_n_d;
    end
  end

  // Ignition can only be held active while the window phase is current.
  a_ignite_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ignite_n_q |-> phase_q == PH_WINDOW)
    else $error("ignition active outside the window phase");

  // The init phase lasts exactly one tick.
  a_init_one_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_INIT |=> phase_q == PH_GROUND || phase_q == PH_GND_CFG)
    else $error("init phase did not resolve after one tick");

endmodule

// ===== hdl/ignition_window_sequencer.sv =====
// ----------------------------------------------------------------------------
// Ignition window sequencer
// Rocket ignition sequencer: one millisecond tick per request, with a
// registered input stage, the phase/timer core and a registered result stage.
// ----------------------------------------------------------------------------
// Path: an accepted request is held in the input stage, and the core result is
// loaded into the result register once that register is empty or being read.
// Throughput: one request per cycle unless the consumer stalls; the input stage
// and result register let a new request in while a finished result is blocked.
// Reset: asynchronous, active low; all phase state, timers and settings
// return to their defaults and both stages come up empty.
module ignition_window_sequencer (
  input  logic     clk_i,
  input  logic     rst_ni,
  iws_in_if.sink   in_i,
  iws_out_if.source res_o,
  iws_cfg_if.sink  cfg_i
);
  import iws_pkg::*;

  cfg_t  cfg;
  item_t in_q;
  logic  in_v_q;
  res_t  res_d, res_q;
  logic  res_v_q;
  logic  advance;

  iws_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  iws_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  assign advance    = in_v_q && (!res_v_q || res_o.ready);
  assign in_i.ready = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_v_q <= 1'b1;
      end else if (advance) begin
        in_v_q <= 1'b0;
      end
      if (advance) begin
        res_v_q <= 1'b1;
      end else if (res_o.ready) begin
        res_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.umbilical_out <= in_i.umbilical_out;
      in_q.switch_one    <= in_i.switch_one;
      in_q.switch_two    <= in_i.switch_two;
      in_q.nose_switch   <= in_i.nose_switch;
      in_q.trajectory_ok <= in_i.trajectory_ok;
      in_q.sensor_sample <= in_i.sensor_sample;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid            = res_v_q;
  assign res_o.phase            = res_q.phase;
  assign res_o.ignite_n         = res_q.ignite_n;
  assign res_o.separated_flag   = res_q.separated_flag;
  assign res_o.status_indicator = res_q.status_indicator;
  assign res_o.log_request      = res_q.log_request;
  assign res_o.sleep_request    = res_q.sleep_request;

  // The input side only stalls when both stages are full and the output is blocked.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_v_q && res_v_q && !res_o.ready)
    else $error("input stalled while a stage had room");

  // A sleep request always comes with a log request.
  a_sleep_logs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && res_q.sleep_request |-> res_q.log_request)
    else $error("sleep request without log request");

endmodule

// ===== tb/tb_ignition_window_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ignition window sequencer testbench
// Drives one flight through ground, takeoff, flying, the ignition window and
// the inhibited phase. A directed table comes first, then random ticks. Each
// accepted tick is run through a local model of the sequencer. Every result is
// checked field by field against the oldest expectation. Both sides idle at
// random, and registers are rewritten between stages while the block is empty.
// ----------------------------------------------------------------------------
module tb_ignition_window_sequencer;
  import iws_pkg::*;

  localparam int unsigned MAX_GAP      = 16;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [CNT24_W-1:0] MAX24 = '1;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    reg_idx_e              idx;
    logic [CFG_DATA_W-1:0] val;
    item_t                 pins;
    logic                  typed;
    res_t                  want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  iws_in_if  in_if ();
  iws_out_if res_if ();
  iws_cfg_if cfg_if ();

  ignition_window_sequencer DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  // Local copy of the settings and of the sequencer state.
  cfg_t               shadow_cfg;
  logic [PHASE_W-1:0] seq_phase;
  logic [CNT24_W-1:0] flight_ms;
  logic [CNT24_W-1:0] sep_ms;
  logic [CNT16_W-1:0] unplug_ms;
  logic [CNT16_W-1:0] eval_tmr;
  logic [CNT16_W-1:0] log_tmr;
  logic               sep_vote;
  logic               contact;
  logic               ign_n;

  res_t        pending_q[$];
  row_t        steps[$];
  int unsigned err_cnt;
  int unsigned tick_cnt;
  bit          burst_mode;
  bit          in_up;
  bit          cfg_up;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [CNT24_W-1:0] bump24(input logic [CNT24_W-1:0] v);
    return (v == MAX24) ? v : v + 24'd1;
  endfunction

  // Advances the local model by one tick and returns the outputs of that tick.
  function automatic res_t step_sequencer(input item_t t);
    res_t         r;
    logic [16:0]  nxt;
    logic [24:0]  win_end;
    logic         lg;
    logic         slp;
    logic         ind;
    lg  = 1'b0;
    slp = 1'b0;
    ind = 1'b1;
    nxt = {1'b0, log_tmr} + 17'd1;
    if (nxt >= {1'b0, shadow_cfg.log_period_ms}) begin
      lg      = 1'b1;
      log_tmr = '0;
    end else begin
      log_tmr = nxt[CNT16_W-1:0];
    end
    sep_ms = sep_vote ? bump24(sep_ms) : '0;
    if (eval_tmr >= shadow_cfg.sample_period_ms) begin
      eval_tmr = '0;
      contact  = t.sensor_sample > shadow_cfg.sensor_threshold;
      sep_vote = (!t.switch_one && !t.switch_two) || (!t.switch_one && !contact) ||
                 (!t.switch_two && !contact);
    end else begin
      eval_tmr = eval_tmr + 16'd1;
    end
    if (seq_phase >= PH_FLYING && seq_phase != PH_GND_CFG) flight_ms = bump24(flight_ms);
    win_end = {1'b0, shadow_cfg.wait_before_window_ms} + {1'b0, shadow_cfg.window_length_ms};
    case (seq_phase)
      PH_INIT: begin
        seq_phase = t.umbilical_out ? PH_GND_CFG : PH_GROUND;
        flight_ms = '0;
        lg        = 1'b1;
      end
      PH_GROUND: begin
        ind = sep_vote;
        if (t.umbilical_out) begin
          if (unplug_ms >= shadow_cfg.debounce_ms) begin
            flight_ms = {8'd0, unplug_ms};
            unplug_ms = '0;
            seq_phase = PH_FLYING;
            lg        = 1'b1;
          end else begin
            unplug_ms = unplug_ms + 16'd1;
          end
        end else begin
          unplug_ms = '0;
        end
      end
      PH_FLYING: begin
        ind = !(sep_vote && !t.nose_switch && t.trajectory_ok);
        if (flight_ms > shadow_cfg.wait_before_window_ms) begin
          seq_phase = PH_WINDOW;
          lg        = 1'b1;
        end
      end
      PH_WINDOW: begin
        ign_n = !((sep_ms > shadow_cfg.separation_delay_ms) && !t.nose_switch &&
                  t.trajectory_ok);
        ind   = !(sep_vote && !t.nose_switch && t.trajectory_ok);
        if ({1'b0, flight_ms} > win_end) begin
          ign_n     = 1'b1;
          ind       = 1'b1;
          seq_phase = PH_INHIBIT;
          lg        = 1'b1;
        end
      end
      PH_GND_CFG: begin
        ind = sep_vote;
      end
      default: begin
        ign_n = 1'b1;
        if (flight_ms > shadow_cfg.sleep_after_ms) begin
          slp = 1'b1;
          lg  = 1'b1;
        end
      end
    endcase
    r.phase            = seq_phase;
    r.ignite_n         = ign_n;
    r.separated_flag   = sep_vote;
    r.status_indicator = ind;
    r.log_request      = lg;
    r.sleep_request    = slp;
    return r;
  endfunction

  function automatic item_t pins(input bit u, input bit s1, input bit s2, input bit nose,
                                 input bit traj, input logic [SAMPLE_W-1:0] smp);
    item_t t;
    t = {u, s1, s2, nose, traj, smp};
    return t;
  endfunction

  function automatic res_t outcome(input phase_e p, input bit ig, input bit sp, input bit ind,
                                   input bit lg, input bit sl);
    res_t r;
    r = {p, ig, sp, ind, lg, sl};
    return r;
  endfunction

  // Switches read 0 (separated) with probability sep_pct; nose in place and
  // trajectory ok each with probability ok_pct.
  function automatic item_t rand_pins(input bit umb, input int unsigned sep_pct,
                                      input int unsigned ok_pct);
    item_t t;
    t.umbilical_out = umb;
    t.switch_one    = $urandom_range(0, 99) >= sep_pct;
    t.switch_two    = $urandom_range(0, 99) >= sep_pct;
    t.nose_switch   = $urandom_range(0, 99) >= ok_pct;
    t.trajectory_ok = $urandom_range(0, 99) < ok_pct;
    case ($urandom_range(0, 3))
      0:       t.sensor_sample = '0;
      1:       t.sensor_sample = '1;
      default: t.sensor_sample = SAMPLE_W'($urandom_range(0, 4095));
    endcase
    return t;
  endfunction

  function automatic void add_tick(input item_t t, input bit typed, input res_t want);
    row_t r;
    r       = '0;
    r.kind  = ROW_TICK;
    r.pins  = t;
    r.typed = typed;
    r.want  = want;
    steps.push_back(r);
  endfunction

  function automatic void add_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] v);
    row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = v;
    steps.push_back(r);
  endfunction

  task automatic push_tick(input item_t t, input bit typed, input res_t want);
    int unsigned gap;
    res_t        guess;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (cfg_up) begin
      cfg_if.valid <= 1'b0;
      cfg_up = 1'b0;
    end
    if (gap != 0) begin
      if (in_up) begin
        in_if.valid <= 1'b0;
        in_up = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.umbilical_out <= t.umbilical_out;
    in_if.switch_one    <= t.switch_one;
    in_if.switch_two    <= t.switch_two;
    in_if.nose_switch   <= t.nose_switch;
    in_if.trajectory_ok <= t.trajectory_ok;
    in_if.sensor_sample <= t.sensor_sample;
    in_up = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    guess = step_sequencer(t);
    pending_q.push_back(typed ? want : guess);
    tick_cnt++;
    if (tick_cnt % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
  endtask

  // Registers change only once every pending result has come back.
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    if (in_up) begin
      in_if.valid <= 1'b0;
      in_up = 1'b0;
    end
    while (pending_q.size() != 0) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    cfg_up = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_SENSOR_THRESHOLD: shadow_cfg.sensor_threshold      = val[SAMPLE_W-1:0];
      REG_SAMPLE_PERIOD:    shadow_cfg.sample_period_ms      = val[CNT16_W-1:0];
      REG_DEBOUNCE:         shadow_cfg.debounce_ms           = val[CNT16_W-1:0];
      REG_WAIT_WINDOW:      shadow_cfg.wait_before_window_ms = val;
      REG_WINDOW_LENGTH:    shadow_cfg.window_length_ms      = val;
      REG_SEP_DELAY:        shadow_cfg.separation_delay_ms   = val;
      REG_SLEEP_AFTER:      shadow_cfg.sleep_after_ms        = val;
      REG_LOG_PERIOD:       shadow_cfg.log_period_ms         = val[CNT16_W-1:0];
      default: ;
    endcase
  endtask

  task automatic shuffle_sampling();
    write_reg(REG_SENSOR_THRESHOLD, CFG_DATA_W'($urandom_range(0, 4095)));
    write_reg(REG_SAMPLE_PERIOD, CFG_DATA_W'($urandom_range(0, 6)));
    write_reg(REG_LOG_PERIOD, CFG_DATA_W'($urandom_range(0, 40)));
  endtask

  // About one tick in ten ignores the bias to break up the sequences.
  task automatic run_ticks(input int unsigned n, input int unsigned sep_pct,
                           input int unsigned ok_pct);
    bit odd;
    repeat (n) begin
      odd = ($urandom_range(0, 9) == 0);
      push_tick(rand_pins(1'($urandom_range(0, 1)), odd ? 50 : sep_pct,
                          odd ? 50 : ok_pct),
                1'b0, '0);
    end
  endtask

  task automatic unplug_bursts(input int unsigned n);
    int unsigned k;
    int unsigned len;
    k = 0;
    while (k < n) begin
      len = $urandom_range(1, 8);
      repeat (len) push_tick(rand_pins(1'b0, 70, 80), 1'b0, '0);
      k += len;
      // A burst never outlasts the debounce time, so each one aborts.
      len = $urandom_range(1, shadow_cfg.debounce_ms);
      repeat (len) push_tick(rand_pins(1'b1, 70, 80), 1'b0, '0);
      k += len;
    end
    push_tick(rand_pins(1'b0, 70, 80), 1'b0, '0);
  endtask

  initial begin : result_sink
    res_t        got;
    res_t        want;
    int unsigned stall;
    bit          held;
    held = 1'b0;
    res_if.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        if (held) res_if.ready <= 1'b0;
        held = 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      held = 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      got = {res_if.phase, res_if.ignite_n, res_if.separated_flag, res_if.status_indicator,
             res_if.log_request, res_if.sleep_request};
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: phase %0d", got.phase);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (got.phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, got.phase);
          err_cnt++;
        end
        if (got.ignite_n !== want.ignite_n) begin
          $error("ignite_n: expected %0b, got %0b", want.ignite_n, got.ignite_n);
          err_cnt++;
        end
        if (got.separated_flag !== want.separated_flag) begin
          $error("separated_flag: expected %0b, got %0b", want.separated_flag,
                 got.separated_flag);
          err_cnt++;
        end
        if (got.status_indicator !== want.status_indicator) begin
          $error("status_indicator: expected %0b, got %0b", want.status_indicator,
                 got.status_indicator);
          err_cnt++;
        end
        if (got.log_request !== want.log_request) begin
          $error("log_request: expected %0b, got %0b", want.log_request, got.log_request);
          err_cnt++;
        end
        if (got.sleep_request !== want.sleep_request) begin
          $error("sleep_request: expected %0b, got %0b", want.sleep_request,
                 got.sleep_request);
          err_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_ignition_window_sequencer: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic [CNT24_W-1:0] span;
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.umbilical_out <= 1'b0;
    in_if.switch_one    <= 1'b1;
    in_if.switch_two    <= 1'b1;
    in_if.nose_switch   <= 1'b0;
    in_if.trajectory_ok <= 1'b0;
    in_if.sensor_sample <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_SENSOR_THRESHOLD;
    cfg_if.data         <= '0;
    err_cnt    = 0;
    tick_cnt   = 0;
    burst_mode = 1'b0;
    in_up      = 1'b0;
    cfg_up     = 1'b0;

    shadow_cfg.sensor_threshold      = RST_SENSOR_THRESHOLD;
    shadow_cfg.sample_period_ms      = RST_SAMPLE_PERIOD;
    shadow_cfg.debounce_ms           = RST_DEBOUNCE;
    shadow_cfg.wait_before_window_ms = RST_WAIT_WINDOW;
    shadow_cfg.window_length_ms      = RST_WINDOW_LENGTH;
    shadow_cfg.separation_delay_ms   = RST_SEP_DELAY;
    shadow_cfg.sleep_after_ms        = RST_SLEEP_AFTER;
    shadow_cfg.log_period_ms         = RST_LOG_PERIOD;
    seq_phase = PH_INIT;
    flight_ms = '0;
    sep_ms    = '0;
    unplug_ms = '0;
    eval_tmr  = '0;
    log_tmr   = '0;
    sep_vote  = 1'b1;
    contact   = 1'b0;
    ign_n     = 1'b1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First tick after reset leaves init for ground and logs the change.
    add_tick(pins(0, 1, 1, 0, 1, 12'd0), 1'b1, outcome(PH_GROUND, 1, 1, 1, 1, 0));
    // Evaluate and log on every tick; any nonzero sample is contact.
    add_reg(REG_SENSOR_THRESHOLD, 24'd0);
    add_reg(REG_SAMPLE_PERIOD, 24'd0);
    add_reg(REG_LOG_PERIOD, 24'd0);
    add_tick(pins(0, 1, 1, 0, 1, 12'd4095), 1'b1, outcome(PH_GROUND, 1, 0, 0, 1, 0));
    add_tick(pins(0, 0, 1, 0, 1, 12'd0), 1'b1, outcome(PH_GROUND, 1, 1, 1, 1, 0));
    add_tick(pins(0, 1, 0, 1, 0, 12'd4095), 1'b1, outcome(PH_GROUND, 1, 0, 0, 1, 0));
    add_tick(pins(0, 0, 0, 1, 0, 12'd4095), 1'b1, outcome(PH_GROUND, 1, 1, 1, 1, 0));
    // With the top threshold no sample counts as contact.
    add_reg(REG_SENSOR_THRESHOLD, 24'd4095);
    add_tick(pins(0, 1, 0, 0, 1, 12'd4095), 1'b1, outcome(PH_GROUND, 1, 1, 1, 1, 0));
    add_reg(REG_LOG_PERIOD, 24'd65535);
    add_reg(REG_DEBOUNCE, 24'd3);
    // Unplugged for exactly the debounce time, then back in: no takeoff.
    add_tick(pins(1, 0, 0, 0, 1, 12'd100), 1'b0, '0);
    add_tick(pins(1, 1, 1, 1, 1, 12'd2000), 1'b0, '0);
    add_tick(pins(1, 0, 1, 0, 0, 12'd2049), 1'b0, '0);
    add_tick(pins(0, 0, 0, 0, 1, 12'd3000), 1'b0, '0);
    add_tick(pins(1, 1, 0, 1, 1, 12'd1), 1'b0, '0);
    add_tick(pins(0, 0, 1, 0, 0, 12'd2048), 1'b0, '0);
    add_reg(REG_SAMPLE_PERIOD, 24'd65535);
    add_tick(pins(0, 1, 1, 1, 0, 12'd4095), 1'b0, '0);
    add_tick(pins(0, 0, 0, 0, 1, 12'd0), 1'b0, '0);
    add_reg(REG_SAMPLE_PERIOD, 24'd2);
    add_tick(pins(0, 1, 1, 0, 1, 12'd3500), 1'b0, '0);
    add_tick(pins(0, 0, 1, 1, 1, 12'd10), 1'b0, '0);

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_CFG) begin
        write_reg(steps[i].idx, steps[i].val);
      end else begin
        push_tick(steps[i].pins, steps[i].typed, steps[i].want);
      end
    end

    // Ground with a debounce no burst can reach.
    shuffle_sampling();
    write_reg(REG_DEBOUNCE, 24'd65535);
    run_ticks(80, 60, 70);

    // Ground with short unplug bursts that all abort.
    shuffle_sampling();
    write_reg(REG_DEBOUNCE, CFG_DATA_W'($urandom_range(20, 40)));
    unplug_bursts(70);
    shuffle_sampling();
    write_reg(REG_DEBOUNCE, CFG_DATA_W'($urandom_range(10, 30)));
    unplug_bursts(70);

    // Takeoff on the first unplugged tick, then fly with the window held off.
    write_reg(REG_DEBOUNCE, 24'd0);
    write_reg(REG_WAIT_WINDOW, MAX24);
    write_reg(REG_WINDOW_LENGTH, 24'd0);
    write_reg(REG_SLEEP_AFTER, MAX24);
    write_reg(REG_SEP_DELAY, 24'd0);
    push_tick(rand_pins(1'b1, 90, 88), 1'b0, '0);
    run_ticks(80, 50, 50);

    // The window opens a few ticks from now; its end overflows 24 bits and
    // so never comes.
    write_reg(REG_WINDOW_LENGTH, MAX24);
    write_reg(REG_WAIT_WINDOW, CFG_DATA_W'(flight_ms + $urandom_range(1, 10)));
    shuffle_sampling();
    run_ticks(70, 92, 90);
    write_reg(REG_SEP_DELAY, 24'd30);
    shuffle_sampling();
    run_ticks(80, 95, 92);
    write_reg(REG_SEP_DELAY, MAX24);
    run_ticks(40, 92, 90);

    // Close the window a few ticks from now, then sit in inhibited.
    span = flight_ms + 24'd5 - shadow_cfg.wait_before_window_ms;
    write_reg(REG_WINDOW_LENGTH, span);
    run_ticks(60, 80, 80);
    write_reg(REG_SLEEP_AFTER, flight_ms + 24'd15);
    write_reg(REG_LOG_PERIOD, CFG_DATA_W'($urandom_range(1, 20)));
    run_ticks(60, 50, 50);
    write_reg(REG_SLEEP_AFTER, 24'd0);
    run_ticks(20, 50, 50);
    write_reg(REG_SLEEP_AFTER, MAX24);
    run_ticks(20, 50, 50);

    if (in_up) in_if.valid <= 1'b0;
    if (cfg_up) cfg_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_ignition_window_sequencer: done, clean");
    end else begin
      $display("tb_ignition_window_sequencer: done, errors");
    end
    $finish;
  end

endmodule
